// ===== hdl/dll_pkg.sv =====
// Shared types and codes for the doubly linked list manager.
`timescale 1ns / 1ps

package dll_pkg;

  // Operation codes carried in the operation field
  typedef enum logic [2:0] {
    OP_ADD_HEAD   = 3'd0,
    OP_ADD_TAIL   = 3'd1,
    OP_REM_HEAD   = 3'd2,
    OP_INS_AFTER  = 3'd3,
    OP_INS_BEFORE = 3'd4,
    OP_REMOVE     = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  // Input word
  typedef struct packed {
    logic [2:0] operation;
    logic [5:0] item_slot;
    logic [5:0] anchor_slot;
  } in_t;

  // Result word
  typedef struct packed {
    logic [5:0] removed_slot;
    logic       removed_valid;
    logic [6:0] entry_count;
    logic       list_empty;
    logic [1:0] status;
  } out_t;

endpackage

// ===== hdl/dll_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dll_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/doubly_linked_list_manager.sv =====
// Top level: one doubly linked list over a pool of slots, kept in link memories.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one operation word:
//   add head, add tail, remove head, insert after, insert before, remove slot.
//   Output channel (out_valid_o / out_ready_i / out_data_o) returns one result
//   word per operation: removed slot, count, empty flag and status.
//   An accepted operation steps through LINK1 and LINK2, and its result enters
//   the output register at the end of LINK2 (or of WAIT while the output stalls).
//   A new operation is taken only back in IDLE. The accept cycle issues the neighbor
//   read of the next and previous link memories; LINK1 and LINK2 use their single
//   write ports for up to four link updates. Count and the on-list marks sit in
//   flip-flops and are decided in the accept cycle, head and tail in the cycle after,
//   so rejects and empty removes pass through the same LINK1 and LINK2 states.
//   Reset clears the list (count zero, no slot listed); the link memories need
//   no clearing since a link is only used for a listed slot.
//   A stalled receiver holds the result in the output register; the next
//   operation is still accepted and worked, and waits for the register to free.
module doubly_linked_list_manager import dll_pkg::*; #(
  parameter int NUM_SLOTS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_LINK1, S_LINK2, S_WAIT} state_e;
  typedef enum logic [2:0] {K_NONE, K_FIRST, K_AFTER, K_BEFORE, K_REMOVE} kind_e;

  state_e              state_q;
  kind_e               kind_q, kind_d;
  logic [SLOT_W-1:0]   x_q, x_d, a_q, a_d, nb_q;
  logic                last_q, link2_q;
  logic [SLOT_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]    cnt_q, cnt_new;
  logic [NUM_SLOTS-1:0] on_list_q;
  out_t                res_q, res_d, out_q;
  logic                out_valid_q;

  logic [SLOT_W-1:0]   item_idx, anchor_idx, rd_addr;
  logic                item_in_pool, anchor_in_pool, item_listed, anchor_listed, item_ok;
  logic                in_fire, set_on, clr_on, out_free, out_load;

  logic                nxt_we, prv_we;
  logic [SLOT_W-1:0]   nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;
  logic [SLOT_W-1:0]   rn, rp;

  // Link memories
  dll_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rn)
  );

  dll_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rp)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = (state_q == S_LINK2 || state_q == S_WAIT) && out_free;

  // Slot lookups on the incoming word
  assign item_idx       = SLOT_W'(in_data_i.item_slot);
  assign anchor_idx     = SLOT_W'(in_data_i.anchor_slot);
  assign item_in_pool   = int'(in_data_i.item_slot) < NUM_SLOTS;
  assign anchor_in_pool = int'(in_data_i.anchor_slot) < NUM_SLOTS;
  assign item_listed    = item_in_pool && on_list_q[item_idx];
  assign anchor_listed  = anchor_in_pool && on_list_q[anchor_idx];
  assign item_ok        = item_in_pool && !item_listed;

  // Decode: checks, count, marks and result are settled in the accept cycle
  always_comb begin
    kind_d  = K_NONE;
    x_d     = item_idx;
    a_d     = anchor_idx;
    cnt_new = cnt_q;
    set_on  = 1'b0;
    clr_on  = 1'b0;
    res_d   = '0;
    res_d.status = ST_DONE;
    case (in_data_i.operation)
      OP_ADD_HEAD, OP_ADD_TAIL: begin
        if (!item_ok) begin
          res_d.status = ST_REJECT;
        end else begin
          set_on  = 1'b1;
          cnt_new = cnt_q + CNT_W'(1);
          if (cnt_q == '0) begin
            kind_d = K_FIRST;
          end else if (in_data_i.operation == OP_ADD_HEAD) begin
            kind_d = K_BEFORE;
            a_d    = head_q;
          end else begin
            kind_d = K_AFTER;
            a_d    = tail_q;
          end
        end
      end
      OP_REM_HEAD: begin
        if (cnt_q == '0) begin
          res_d.status = ST_EMPTY;
        end else begin
          kind_d  = K_REMOVE;
          x_d     = head_q;
          clr_on  = 1'b1;
          cnt_new = cnt_q - CNT_W'(1);
          res_d.removed_slot  = 6'(head_q);
          res_d.removed_valid = 1'b1;
        end
      end
      OP_INS_AFTER, OP_INS_BEFORE: begin
        if (!item_ok || !anchor_listed) begin
          res_d.status = ST_REJECT;
        end else begin
          set_on  = 1'b1;
          cnt_new = cnt_q + CNT_W'(1);
          kind_d  = (in_data_i.operation == OP_INS_AFTER) ? K_AFTER : K_BEFORE;
        end
      end
      OP_REMOVE: begin
        if (!item_listed) begin
          res_d.status = ST_REJECT;
        end else begin
          kind_d  = K_REMOVE;
          clr_on  = 1'b1;
          cnt_new = cnt_q - CNT_W'(1);
        end
      end
      default: begin
        res_d.status = ST_REJECT;
      end
    endcase
    res_d.entry_count = 7'(cnt_new);
    res_d.list_empty  = (cnt_new == '0);
  end

  // Neighbor read: the removed slot's links, or the anchor's links
  assign rd_addr = (kind_d == K_REMOVE) ? x_d : a_d;

  // Link updates: first batch in LINK1, interior insert finish in LINK2
  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = x_q;
    nxt_wdata = a_q;
    prv_we    = 1'b0;
    prv_waddr = x_q;
    prv_wdata = a_q;
    head_d    = head_q;
    tail_d    = tail_q;
    if (state_q == S_LINK1) begin
      case (kind_q)
        K_FIRST: begin
          head_d = x_q;
          tail_d = x_q;
        end
        K_AFTER: begin
          nxt_we    = 1'b1;
          nxt_waddr = a_q;
          nxt_wdata = x_q;
          prv_we    = 1'b1;
          if (a_q == tail_q) begin
            prv_waddr = x_q;
            prv_wdata = a_q;
            tail_d    = x_q;
          end else begin
            prv_waddr = rn;
            prv_wdata = x_q;
          end
        end
        K_BEFORE: begin
          nxt_we    = 1'b1;
          prv_we    = 1'b1;
          prv_waddr = a_q;
          prv_wdata = x_q;
          if (a_q == head_q) begin
            nxt_waddr = x_q;
            nxt_wdata = a_q;
            head_d    = x_q;
          end else begin
            nxt_waddr = rp;
            nxt_wdata = x_q;
          end
        end
        K_REMOVE: begin
          if (last_q) begin
            head_d = '0;
            tail_d = '0;
          end else begin
            if (x_q == head_q) begin
              head_d = rn;
            end else begin
              nxt_we    = 1'b1;
              nxt_waddr = rp;
              nxt_wdata = rn;
            end
            if (x_q == tail_q) begin
              tail_d = rp;
            end else begin
              prv_we    = 1'b1;
              prv_waddr = rn;
              prv_wdata = rp;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (state_q == S_LINK2 && link2_q) begin
      nxt_we    = 1'b1;
      prv_we    = 1'b1;
      nxt_waddr = x_q;
      prv_waddr = x_q;
      if (kind_q == K_AFTER) begin
        nxt_wdata = nb_q;
        prv_wdata = a_q;
      end else begin
        nxt_wdata = a_q;
        prv_wdata = nb_q;
      end
    end
  end

  // Sequencer, list registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= K_NONE;
      x_q         <= '0;
      a_q         <= '0;
      nb_q        <= '0;
      last_q      <= 1'b0;
      link2_q     <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      on_list_q   <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Output register: load a finished result, else drop an accepted one
      if (out_load) begin
        out_q       <= res_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      head_q <= head_d;
      tail_q <= tail_d;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            kind_q <= kind_d;
            x_q    <= x_d;
            a_q    <= a_d;
            last_q <= (cnt_q == CNT_W'(1));
            res_q  <= res_d;
            cnt_q  <= cnt_new;
            if (set_on) begin
              on_list_q[item_idx] <= 1'b1;
            end
            if (clr_on) begin
              on_list_q[x_d] <= 1'b0;
            end
            state_q <= S_LINK1;
          end
        end
        S_LINK1: begin
          link2_q <= (kind_q == K_AFTER && a_q != tail_q) ||
                     (kind_q == K_BEFORE && a_q != head_q);
          nb_q    <= (kind_q == K_AFTER) ? rn : rp;
          state_q <= S_LINK2;
        end
        S_LINK2, S_WAIT: begin
          link2_q <= 1'b0;
          if (out_free) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_WAIT;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
